@@ rtl/core/ptt_pkg.sv @@
package ptt_pkg;

	localparam logic       MODE_TICK   = 1'b0;
	localparam logic       MODE_REG    = 1'b1;

	localparam logic [1:0] KIND_PING   = 2'd0;
	localparam logic [1:0] KIND_REG    = 2'd1;
	localparam logic [1:0] KIND_FULL   = 2'd2;

	localparam logic [7:0] TICK_RESET  = 8'd5;
	localparam int         MAX_RESULTS = 8;
	localparam int         CNT_W       = $clog2(MAX_RESULTS + 1);

	typedef struct packed {
		logic        mode;
		logic [7:0]  client_id;
		logic [30:0] delay_ms;
		logic [30:0] repeat_ms;
	} in_item_t;

	typedef struct packed {
		logic [1:0]  kind;
		logic [7:0]  client_out;
		logic [31:0] due_time;
		logic [2:0]  slot_out;
		logic        last;
	} out_item_t;

	typedef struct packed {
		logic [7:0]  client;
		logic [31:0] due;
		logic [30:0] period;
	} slot_rec_t;

	typedef struct packed {
		logic load;
		logic idx_inc;
		logic emit_reg;
		logic emit_full;
		logic hit;
		logic flush;
	} ctrl_cmd_t;

	typedef struct packed {
		logic busy_at_idx;
		logic hit;
		logic idx_last;
		logic ping_last;
		logic hold_valid;
		logic out_free;
	} dp_status_t;

endpackage

@@ rtl/core/ptt_ram.sv @@
module ptt_ram #(
	parameter int WIDTH = 71,
	parameter int DEPTH = 8
) (
	input  logic                                          clk,
	input  logic                                          we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                              wdata,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                              rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

@@ rtl/core/ptt_ctrl.sv @@
module ptt_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	input  logic                in_mode,
	output logic                in_stall,
	input  ptt_pkg::dp_status_t status,
	output ptt_pkg::ctrl_cmd_t  cmd
);

	import ptt_pkg::*;

	localparam logic [2:0] ST_IDLE     = 3'd0;
	localparam logic [2:0] ST_REG_SCAN = 3'd1;
	localparam logic [2:0] ST_REG_OK   = 3'd2;
	localparam logic [2:0] ST_REG_FULL = 3'd3;
	localparam logic [2:0] ST_TICK_RD  = 3'd4;
	localparam logic [2:0] ST_TICK_CHK = 3'd5;
	localparam logic [2:0] ST_TICK_END = 3'd6;

	logic [2:0] state_q;
	logic [2:0] state_d;

	assign in_stall = (state_q != ST_IDLE);

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = (in_mode == MODE_REG) ? ST_REG_SCAN : ST_TICK_RD;
				end
			end
			ST_REG_SCAN: begin
				if (!status.busy_at_idx) begin
					state_d = ST_REG_OK;
				end else if (status.idx_last) begin
					state_d = ST_REG_FULL;
				end else begin
					cmd.idx_inc = 1'b1;
				end
			end
			ST_REG_OK: begin
				if (status.out_free) begin
					cmd.emit_reg = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			ST_REG_FULL: begin
				if (status.out_free) begin
					cmd.emit_full = 1'b1;
					state_d       = ST_IDLE;
				end
			end
			ST_TICK_RD: begin
				state_d = ST_TICK_CHK;
			end
			ST_TICK_CHK: begin
				if (status.hit) begin
					if (!status.hold_valid || status.out_free) begin
						cmd.hit = 1'b1;
						if (status.ping_last || status.idx_last) begin
							state_d = ST_TICK_END;
						end else begin
							cmd.idx_inc = 1'b1;
							state_d     = ST_TICK_RD;
						end
					end
				end else if (status.idx_last) begin
					state_d = ST_TICK_END;
				end else begin
					cmd.idx_inc = 1'b1;
					state_d     = ST_TICK_RD;
				end
			end
			ST_TICK_END: begin
				if (!status.hold_valid) begin
					state_d = ST_IDLE;
				end else if (status.out_free) begin
					cmd.flush = 1'b1;
					state_d   = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

@@ rtl/core/ptt_dp.sv @@
module ptt_dp #(
	parameter int TIMER_SLOTS = 8
) (
	input  logic                clk,
	input  logic                arst_n,
	input  ptt_pkg::ctrl_cmd_t  cmd,
	output ptt_pkg::dp_status_t status,
	input  ptt_pkg::in_item_t   in_item,
	output logic                out_valid,
	input  logic                out_stall,
	output ptt_pkg::out_item_t  out_item,
	input  logic                cfg_we,
	input  logic [7:0]          cfg_wdata
);

	import ptt_pkg::*;

	localparam int IDX_W = (TIMER_SLOTS > 1) ? $clog2(TIMER_SLOTS) : 1;

	logic [31:0]            now_q;
	logic [7:0]             tick_q;
	logic [TIMER_SLOTS-1:0] busy_q;
	logic [IDX_W-1:0]       idx_q;
	logic [CNT_W-1:0]       cnt_q;
	logic                   hold_valid_q;
	logic                   out_valid_q;
	in_item_t               item_q;
	out_item_t              hold_q;
	out_item_t              out_q;

	slot_rec_t              rd_rec;
	slot_rec_t              wr_rec;
	logic                   ram_we;
	logic [IDX_W+2:0]       idx_ext;
	logic [2:0]             slot_id;
	logic [31:0]            new_due;
	logic                   periodic;
	logic                   out_load;

	assign idx_ext  = {3'b000, idx_q};
	assign slot_id  = idx_ext[2:0];
	assign new_due  = now_q + {1'b0, item_q.delay_ms};
	assign periodic = (rd_rec.period != 31'd0);

	assign ram_we = cmd.emit_reg | (cmd.hit & periodic);

	assign out_load = cmd.emit_reg | cmd.emit_full | (cmd.hit & hold_valid_q) | cmd.flush;

	always_comb begin
		if (cmd.emit_reg) begin
			wr_rec.client = item_q.client_id;
			wr_rec.due    = new_due;
			wr_rec.period = item_q.repeat_ms;
		end else begin
			wr_rec.client = rd_rec.client;
			wr_rec.due    = rd_rec.due + {1'b0, rd_rec.period};
			wr_rec.period = rd_rec.period;
		end
	end

	ptt_ram #(
		.WIDTH($bits(slot_rec_t)),
		.DEPTH(TIMER_SLOTS)
	) u_slot_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(idx_q),
		.wdata(wr_rec),
		.raddr(idx_q),
		.rdata(rd_rec)
	);

	assign status.busy_at_idx = busy_q[idx_q];
	assign status.hit         = busy_q[idx_q] && (now_q >= rd_rec.due);
	assign status.idx_last    = (idx_q == IDX_W'(TIMER_SLOTS - 1));
	assign status.ping_last   = (cnt_q == CNT_W'(MAX_RESULTS - 1));
	assign status.hold_valid  = hold_valid_q;
	assign status.out_free    = !out_valid_q || !out_stall;

	assign out_valid = out_valid_q;
	assign out_item  = out_q;

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			now_q        <= '0;
			tick_q       <= TICK_RESET;
			busy_q       <= '0;
			idx_q        <= '0;
			cnt_q        <= '0;
			hold_valid_q <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			if (cfg_we) begin
				tick_q <= cfg_wdata;
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			if (cmd.load) begin
				idx_q <= '0;
				cnt_q <= '0;
				if (in_item.mode == MODE_TICK) begin
					now_q <= now_q + {24'd0, tick_q};
				end
			end
			if (cmd.idx_inc) begin
				idx_q <= idx_q + 1'b1;
			end
			if (cmd.emit_reg) begin
				busy_q[idx_q] <= 1'b1;
			end
			if (cmd.hit) begin
				cnt_q        <= cnt_q + 1'b1;
				hold_valid_q <= 1'b1;
				if (!periodic) begin
					busy_q[idx_q] <= 1'b0;
				end
			end
			if (cmd.flush) begin
				hold_valid_q <= 1'b0;
			end
		end
	end

	// payload
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			item_q <= in_item;
		end
		if (cmd.emit_reg) begin
			out_q.kind       <= KIND_REG;
			out_q.client_out <= item_q.client_id;
			out_q.due_time   <= new_due;
			out_q.slot_out   <= slot_id;
			out_q.last       <= 1'b1;
		end
		if (cmd.emit_full) begin
			out_q.kind       <= KIND_FULL;
			out_q.client_out <= item_q.client_id;
			out_q.due_time   <= '0;
			out_q.slot_out   <= '0;
			out_q.last       <= 1'b1;
		end
		if (cmd.hit) begin
			hold_q.kind       <= KIND_PING;
			hold_q.client_out <= rd_rec.client;
			hold_q.due_time   <= rd_rec.due;
			hold_q.slot_out   <= slot_id;
			hold_q.last       <= 1'b0;
			if (hold_valid_q) begin
				out_q <= hold_q;
			end
		end
		if (cmd.flush) begin
			out_q.kind       <= hold_q.kind;
			out_q.client_out <= hold_q.client_out;
			out_q.due_time   <= hold_q.due_time;
			out_q.slot_out   <= hold_q.slot_out;
			out_q.last       <= 1'b1;
		end
	end

endmodule

@@ rtl/core/periodic_timer_table.sv @@
// Table of TIMER_SLOTS software timers on a 32-bit millisecond clock. A register
// item takes the lowest free slot and answers with one result (registered, or
// table full); a tick item adds the tick value (reset to 5, set through cfg_wdata)
// to the clock and then gives one ping per due slot in slot order, at most eight,
// the final one flagged last. One item is worked on at a time. A register item
// scans the busy flags from slot zero up to the first free slot; a tick item
// reads and then checks each slot in turn, since the slot records sit in a RAM
// with a registered read that the scan visits one slot at a time. A stalled
// output holds the work on the item until the output is free. Slot records need
// no clearing after reset: only the per-slot busy flags are reset.
module periodic_timer_table #(
	parameter int TIMER_SLOTS = 8
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  ptt_pkg::in_item_t  in_item,
	output logic               out_valid,
	input  logic               out_stall,
	output ptt_pkg::out_item_t out_item,
	input  logic               cfg_we,
	input  logic [7:0]         cfg_wdata
);

	import ptt_pkg::*;

	ctrl_cmd_t  cmd;
	dp_status_t status;

	ptt_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_valid(in_valid),
		.in_mode (in_item.mode),
		.in_stall(in_stall),
		.status  (status),
		.cmd     (cmd)
	);

	ptt_dp #(
		.TIMER_SLOTS(TIMER_SLOTS)
	) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.status   (status),
		.in_item  (in_item),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_item (out_item),
		.cfg_we   (cfg_we),
		.cfg_wdata(cfg_wdata)
	);

endmodule
